// ===== src/ihb_pkg.sv =====
// Shared types, constants and word selection for the IPv4 header builder.
package ihb_pkg;

  localparam int unsigned NUM_WORDS   = 10;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned SUM_W       = 19;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [7:0]  TTL_VALUE    = 8'd64;
  localparam logic [15:0] HDR_BYTES    = 16'd20;

  // Word positions within the header
  localparam logic [IDX_W-1:0] W_VER    = 4'd0;
  localparam logic [IDX_W-1:0] W_LEN    = 4'd1;
  localparam logic [IDX_W-1:0] W_ID     = 4'd2;
  localparam logic [IDX_W-1:0] W_FRAG   = 4'd3;
  localparam logic [IDX_W-1:0] W_TTL    = 4'd4;
  localparam logic [IDX_W-1:0] W_CSUM   = 4'd5;
  localparam logic [IDX_W-1:0] W_SRC_HI = 4'd6;
  localparam logic [IDX_W-1:0] W_SRC_LO = 4'd7;
  localparam logic [IDX_W-1:0] W_DST_HI = 4'd8;
  localparam logic [IDX_W-1:0] W_DST_LO = 4'd9;
  localparam logic [IDX_W-1:0] LAST_IDX = W_DST_LO;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [15:0] checksum;
  } hdr_rec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  function automatic logic [15:0] word_sel(input hdr_rec_t rec, input logic [IDX_W-1:0] idx);
    logic [15:0] w;
    w = '0;
    unique case (idx)
      W_VER:    w = VER_IHL_WORD;
      W_LEN:    w = rec.total_len;
      W_ID:     w = '0;
      W_FRAG:   w = '0;
      W_TTL:    w = {TTL_VALUE, rec.proto};
      W_CSUM:   w = rec.checksum;
      W_SRC_HI: w = rec.src[31:16];
      W_SRC_LO: w = rec.src[15:0];
      W_DST_HI: w = rec.dst[31:16];
      W_DST_LO: w = rec.dst[15:0];
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/ihb_in_if.sv =====
// Input channel: one datagram description per beat.
interface ihb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] target_address;
  logic [7:0]  protocol_number;
  logic [15:0] payload_length;

  modport source (output valid, source_address, target_address, protocol_number,
                  payload_length, input ready);
  modport sink (input valid, source_address, target_address, protocol_number,
                payload_length, output ready);
endinterface

// ===== src/ihb_out_if.sv =====
// Output channel: one 16-bit header word per beat.
interface ihb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_word;
  logic [3:0]  word_index;
  logic        last_word;

  modport source (output valid, header_word, word_index, last_word, input ready);
  modport sink (input valid, header_word, word_index, last_word, output ready);
endinterface

// ===== src/ihb_front.sv =====
// Front end: accept a datagram, form total length and raw sum, fold into the checksum.
module ihb_front (
  input  logic             clk,
  input  logic             rst_n,
  ihb_in_if.sink           in_ch,
  output logic             push_valid,
  output ihb_pkg::hdr_rec_t push_rec,
  input  logic             push_ready
);
  import ihb_pkg::*;

  logic             st_valid_r, st_valid_nxt;
  logic [31:0]      st_src_r;
  logic [31:0]      st_dst_r;
  logic [7:0]       st_proto_r;
  logic [15:0]      st_len_r;
  logic [SUM_W-1:0] st_sum_r;

  logic             take;
  logic [15:0]      total_len;
  logic [SUM_W-1:0] raw_sum;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign in_ch.ready = !st_valid_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Total length wraps modulo 2^16
  assign total_len = in_ch.payload_length + HDR_BYTES;

  // Checksum field counts as zero; ID and fragment words are zero
  assign raw_sum = SUM_W'(VER_IHL_WORD)
                 + SUM_W'(total_len)
                 + SUM_W'({TTL_VALUE, in_ch.protocol_number})
                 + SUM_W'(in_ch.source_address[31:16])
                 + SUM_W'(in_ch.source_address[15:0])
                 + SUM_W'(in_ch.target_address[31:16])
                 + SUM_W'(in_ch.target_address[15:0]);

  always_comb begin
    st_valid_nxt = st_valid_r;
    if (take) begin
      st_valid_nxt = 1'b1;
    end else if (push_ready) begin
      st_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st_src_r   <= in_ch.source_address;
      st_dst_r   <= in_ch.target_address;
      st_proto_r <= in_ch.protocol_number;
      st_len_r   <= total_len;
      st_sum_r   <= raw_sum;
    end
  end

  // Two end-around carry folds bring the sum to 16 bits
  assign fold1 = 17'(st_sum_r[15:0]) + 17'(st_sum_r[SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  assign push_valid         = st_valid_r;
  assign push_rec.src       = st_src_r;
  assign push_rec.dst       = st_dst_r;
  assign push_rec.proto     = st_proto_r;
  assign push_rec.total_len = st_len_r;
  assign push_rec.checksum  = ~fold2;

endmodule

// ===== src/ihb_queue.sv =====
// Short header-record queue between the front and back ends.
module ihb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  ihb_pkg::hdr_rec_t push_rec,
  input  logic              pop,
  output ihb_pkg::hdr_rec_t head_rec,
  output ihb_pkg::q_stat_t  stat
);
  import ihb_pkg::*;

  hdr_rec_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign stat.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.not_empty = (count_r != '0);
  assign do_push        = push_valid && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head_rec       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== src/ihb_back.sv =====
// Back end: walk the head record word by word into the output register.
module ihb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ihb_pkg::hdr_rec_t head_rec,
  input  ihb_pkg::q_stat_t  stat,
  output logic              pop,
  ihb_out_if.source         out_ch
);
  import ihb_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      word_r;
  logic [IDX_W-1:0] word_idx_r;
  logic             last_r;
  logic             load;
  logic             at_last;

  assign load    = stat.not_empty && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == LAST_IDX);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = at_last ? '0 : idx_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r     <= word_sel(head_rec, idx_r);
      word_idx_r <= idx_r;
      last_r     <= at_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.header_word = word_r;
  assign out_ch.word_index  = word_idx_r;
  assign out_ch.last_word   = last_r;

endmodule

// ===== src/ipv4_header_builder.sv =====
// Top level of the IPv4 header builder: front end, record queue, word serializer.
// The first header word passes through the front stage, the queue and the output register.
// Throughput: ten output beats per input beat, set by the back end emitting one 16-bit
// word per cycle while out_ch.ready is high; input beats are taken
// while earlier headers drain, up to one in the front stage and two queued.
// Reset (synchronous, rst_n low) empties the front stage, queue and output register.
module ipv4_header_builder (
  input  logic       clk,
  input  logic       rst_n,
  ihb_in_if.sink     in_ch,
  ihb_out_if.source  out_ch
);
  import ihb_pkg::*;

  // Front to queue
  logic     push_valid;
  hdr_rec_t push_rec;

  // Queue to back
  hdr_rec_t head_rec;
  q_stat_t  q_stat;
  logic     pop;

  // Accept beats and compute total length and checksum; hold while the queue is full.
  ihb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .push_ready (!q_stat.full)
  );

  // Decouple the sides so a stalled output does not stall the next datagram at once.
  ihb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_rec   (head_rec),
    .stat       (q_stat)
  );

  // Advance through the ten words of the head record; drop it after the last word.
  ihb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .stat     (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // The last flag marks exactly the final word position.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == LAST_IDX)))
    else $error("last_word does not match word_index");

  // After a non-final beat is taken, the next word follows in order.
  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_word) |=>
      (out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 4'd1))
    else $error("header words out of order");

  // A header is popped only when it still sits in the queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

  // The front stage never releases a record into a full queue as accepted.
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && q_stat.full) |=> push_valid)
    else $error("front stage dropped a record");

endmodule
